// ----- hdl/pfc_pkg.sv -----
// pfc_pkg: types, codes and square helpers for the playfair stream cipher
// no dependencies; imported by playfair_stream_cipher_top

package pfc_pkg;

    localparam int SQUARE_SIDE = 5;
    localparam int CELL_COUNT  = SQUARE_SIDE * SQUARE_SIDE;
    localparam int CELL_W      = 5;
    localparam int CFG_W       = 60;
    localparam int CFG_ADDR_W  = 2;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_CELLS_LOW  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CELLS_HIGH = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CELL_FINAL = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DECRYPT    = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DOUBLE   = 2'd1;
    localparam logic [1:0] ST_XX       = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam logic [4:0] LETTER_I  = 5'd8;
    localparam logic [4:0] LETTER_J  = 5'd9;
    localparam logic [4:0] LETTER_X  = 5'd23;
    localparam logic [4:0] LAST_CELL = 5'(CELL_COUNT - 1);
    localparam logic [7:0] CHAR_LA   = 8'h61;
    localparam logic [7:0] CHAR_LZ   = 8'h7a;
    localparam logic [7:0] CHAR_UA   = 8'h41;
    localparam logic [7:0] CHAR_UZ   = 8'h5a;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last_of_run;
        logic [1:0] status;
    } out_item_t;

    // row of a cell index below 25: idx*13 >> 6
    function automatic logic [2:0] cell_row(input logic [4:0] idx);
        logic [9:0] prod;
        prod = {5'd0, idx} * 10'd13;
        return prod[8:6];
    endfunction

    function automatic logic [2:0] cell_col(input logic [4:0] idx);
        logic [4:0] base;
        base = {2'd0, cell_row(idx)} * 5'(SQUARE_SIDE);
        return 3'(idx - base);
    endfunction

    // one step along a row or column with wrap-around
    function automatic logic [2:0] step_coord(input logic [2:0] c, input logic back);
        logic [2:0] res;
        if (back) begin
            res = (c == 3'd0) ? 3'(SQUARE_SIDE - 1) : c - 3'd1;
        end else begin
            res = (c == 3'(SQUARE_SIDE - 1)) ? 3'd0 : c + 3'd1;
        end
        return res;
    endfunction

    function automatic logic [4:0] cell_index(input logic [2:0] r, input logic [2:0] c);
        return 5'({2'd0, r} * 5'(SQUARE_SIDE) + {2'd0, c});
    endfunction

    function automatic logic [4:0] lookup_key(input logic [4:0] letter);
        return (letter == LETTER_J) ? LETTER_I : letter;
    endfunction

endpackage

// ----- hdl/playfair_stream_cipher_top.sv -----
// playfair stream cipher: sequencer, shared cell scanner and gap buffer
// imports pfc_pkg
// a passed-through byte, or an error found at decode, is registered from the decode
// state once the output slot is free, and the input is ready again back in idle.
// a pair (or a flush) adds two or three scans (one cell per cycle, first match stops)
// and a plan state, then each cipher letter and each gap byte (read, then sent) goes
// out; a doubled pair in decrypt reports after the scans; m_ready low stalls output.
// reset (aresetn low, synchronous) clears the sequencer, pending letter, gap
// count, error latch and square registers; gap contents stay undefined.
module playfair_stream_cipher_top #(
    parameter int GAP_DEPTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [pfc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [pfc_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  pfc_pkg::in_item_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output pfc_pkg::out_item_t                m_data
);
    import pfc_pkg::*;

    localparam int GAP_CW = $clog2(GAP_DEPTH + 1);
    localparam int GAP_IW = (GAP_DEPTH > 1) ? $clog2(GAP_DEPTH) : 1;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECODE = 9'b000000010,
        S_LOC1   = 9'b000000100,
        S_LOC2   = 9'b000001000,
        S_PLAN   = 9'b000010000,
        S_OUT1   = 9'b000100000,
        S_GAPRD  = 9'b001000000,
        S_GAP    = 9'b010000000,
        S_OUT2   = 9'b100000000
    } state_t;

    // square and mode
    logic [CFG_W-1:0]  cells_low_reg, cells_high_reg;
    logic [CELL_W-1:0] cell_final_reg;
    logic              decrypt_reg;

    state_t            state_reg, state_next;
    logic [7:0]        ch_reg, ch_next;
    logic              eot_reg, eot_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [4:0]        pend_letter_reg, pend_letter_next;
    logic              pend_upper_reg, pend_upper_next;
    logic [4:0]        sec_letter_reg, sec_letter_next;
    logic              sec_upper_reg, sec_upper_next;
    logic              doubled_reg, doubled_next;
    logic [4:0]        scan_k_reg, scan_k_next;
    logic [4:0]        pos1_reg, pos1_next;
    logic [4:0]        pos2_reg, pos2_next;
    logic [4:0]        o1_reg, o1_next;
    logic [4:0]        o2_reg, o2_next;
    logic [GAP_CW-1:0] gap_count_reg, gap_count_next;
    logic [GAP_IW-1:0] gap_idx_reg, gap_idx_next;
    logic [1:0]        error_latch_reg, error_latch_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;

    logic [7:0]        gap_mem [GAP_DEPTH];
    logic [7:0]        gap_rd_data_reg;
    logic              gap_we;

    logic [CELL_COUNT*CELL_W-1:0] square_vec;
    logic [4:0]        cell_sel;
    logic [4:0]        cell_val;
    logic [6:0]        cell_base;
    logic [4:0]        scan_key;
    logic              scan_hit;
    logic              out_free;
    logic              is_upper, is_lower, is_letter;
    logic [4:0]        cur_letter;
    logic [7:0]        letter_off;
    logic [2:0]        r1, c1, r2, c2;

    assign square_vec = {cell_final_reg, cells_high_reg, cells_low_reg};
    assign cell_base  = {2'd0, cell_sel} * 7'd5;
    assign cell_val   = square_vec[cell_base +: CELL_W];

    assign is_upper   = (ch_reg >= CHAR_UA) && (ch_reg <= CHAR_UZ);
    assign is_lower   = (ch_reg >= CHAR_LA) && (ch_reg <= CHAR_LZ);
    assign is_letter  = is_upper || is_lower;
    assign letter_off = ch_reg - (is_upper ? CHAR_UA : CHAR_LA);
    assign cur_letter = letter_off[4:0];

    assign scan_key = (state_reg == S_LOC1) ? lookup_key(pend_letter_reg)
                                            : lookup_key(sec_letter_reg);
    assign scan_hit = (cell_val == scan_key);

    assign r1 = cell_row(pos1_reg);
    assign c1 = cell_col(pos1_reg);
    assign r2 = cell_row(pos2_reg);
    assign c2 = cell_col(pos2_reg);

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    always_comb begin
        case (state_reg)
            S_OUT1:  cell_sel = o1_reg;
            S_OUT2:  cell_sel = o2_reg;
            default: cell_sel = scan_k_reg;
        endcase
    end

    always_comb begin
        state_next       = state_reg;
        ch_next          = ch_reg;
        eot_next         = eot_reg;
        pend_valid_next  = pend_valid_reg;
        pend_letter_next = pend_letter_reg;
        pend_upper_next  = pend_upper_reg;
        sec_letter_next  = sec_letter_reg;
        sec_upper_next   = sec_upper_reg;
        doubled_next     = doubled_reg;
        scan_k_next      = scan_k_reg;
        pos1_next        = pos1_reg;
        pos2_next        = pos2_reg;
        o1_next          = o1_reg;
        o2_next          = o2_reg;
        gap_count_next   = gap_count_reg;
        gap_idx_next     = gap_idx_reg;
        error_latch_next = error_latch_reg;
        out_valid_next   = out_valid_reg && !m_ready;
        out_data_next    = out_data_reg;
        gap_we           = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    ch_next    = s_data.char_in;
                    eot_next   = s_data.end_of_text;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                // wait for a free output slot so any single result can go out here
                if (out_free) begin
                    state_next   = S_IDLE;
                    doubled_next = 1'b0;
                    scan_k_next  = 5'd0;
                    if (error_latch_reg != ST_OK) begin
                        out_valid_next = 1'b1;
                        out_data_next  = '{char_out: 8'd0, last_of_run: 1'b1,
                                          status: error_latch_reg};
                    end else if (eot_reg) begin
                        if (pend_valid_reg) begin
                            if (pend_letter_reg == LETTER_X) begin
                                out_valid_next   = 1'b1;
                                out_data_next    = '{char_out: 8'd0, last_of_run: 1'b1,
                                                    status: ST_XX};
                                error_latch_next = ST_XX;
                                pend_valid_next  = 1'b0;
                                gap_count_next   = '0;
                            end else begin
                                sec_letter_next = LETTER_X;
                                sec_upper_next  = 1'b0;
                                state_next      = S_LOC1;
                            end
                        end
                    end else if (!is_letter) begin
                        if (!pend_valid_reg) begin
                            out_valid_next = 1'b1;
                            out_data_next  = '{char_out: ch_reg, last_of_run: 1'b1,
                                              status: ST_OK};
                        end else if (gap_count_reg == GAP_CW'(GAP_DEPTH)) begin
                            out_valid_next   = 1'b1;
                            out_data_next    = '{char_out: 8'd0, last_of_run: 1'b1,
                                                status: ST_OVERFLOW};
                            error_latch_next = ST_OVERFLOW;
                            pend_valid_next  = 1'b0;
                            gap_count_next   = '0;
                        end else begin
                            gap_we         = 1'b1;
                            gap_count_next = gap_count_reg + 1'b1;
                        end
                    end else if (!pend_valid_reg) begin
                        pend_valid_next  = 1'b1;
                        pend_letter_next = cur_letter;
                        pend_upper_next  = is_upper;
                    end else if (pend_letter_reg == LETTER_X && cur_letter == LETTER_X) begin
                        out_valid_next   = 1'b1;
                        out_data_next    = '{char_out: 8'd0, last_of_run: 1'b1,
                                            status: ST_XX};
                        error_latch_next = ST_XX;
                        pend_valid_next  = 1'b0;
                        gap_count_next   = '0;
                    end else begin
                        sec_letter_next = cur_letter;
                        sec_upper_next  = is_upper;
                        state_next      = S_LOC1;
                    end
                end
            end
            S_LOC1: begin
                // first matching cell wins; no match leaves cell 0
                if (scan_hit || scan_k_reg == LAST_CELL) begin
                    pos1_next   = scan_hit ? scan_k_reg : 5'd0;
                    scan_k_next = 5'd0;
                    state_next  = S_LOC2;
                end else begin
                    scan_k_next = scan_k_reg + 5'd1;
                end
            end
            S_LOC2: begin
                if (scan_hit || scan_k_reg == LAST_CELL) begin
                    pos2_next   = scan_hit ? scan_k_reg : 5'd0;
                    scan_k_next = 5'd0;
                    state_next  = S_PLAN;
                end else begin
                    scan_k_next = scan_k_reg + 5'd1;
                end
            end
            S_PLAN: begin
                if (!eot_reg && !doubled_reg && pos1_reg == pos2_reg) begin
                    if (decrypt_reg) begin
                        if (out_free) begin
                            out_valid_next   = 1'b1;
                            out_data_next    = '{char_out: 8'd0, last_of_run: 1'b1,
                                                status: ST_DOUBLE};
                            error_latch_next = ST_DOUBLE;
                            pend_valid_next  = 1'b0;
                            gap_count_next   = '0;
                            state_next       = S_IDLE;
                        end
                    end else begin
                        // doubled pair: filler x takes the second place, rescan it
                        doubled_next    = 1'b1;
                        sec_letter_next = LETTER_X;
                        sec_upper_next  = 1'b0;
                        state_next      = S_LOC2;
                    end
                end else begin
                    if (r1 == r2) begin
                        o1_next = cell_index(r1, step_coord(c1, decrypt_reg));
                        o2_next = cell_index(r2, step_coord(c2, decrypt_reg));
                    end else if (c1 == c2) begin
                        o1_next = cell_index(step_coord(r1, decrypt_reg), c1);
                        o2_next = cell_index(step_coord(r2, decrypt_reg), c2);
                    end else begin
                        o1_next = cell_index(r1, c2);
                        o2_next = cell_index(r2, c1);
                    end
                    state_next = S_OUT1;
                end
            end
            S_OUT1: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{char_out: (pend_upper_reg ? CHAR_UA : CHAR_LA)
                                                 + {3'd0, cell_val},
                                      last_of_run: 1'b0, status: ST_OK};
                    gap_idx_next   = '0;
                    state_next     = (gap_count_reg != '0) ? S_GAPRD : S_OUT2;
                end
            end
            S_GAPRD: begin
                // read data register picks up the entry at gap_idx_reg
                state_next = S_GAP;
            end
            S_GAP: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{char_out: gap_rd_data_reg, last_of_run: 1'b0,
                                      status: ST_OK};
                    if (GAP_CW'(gap_idx_reg) + 1'b1 == gap_count_reg) begin
                        state_next = S_OUT2;
                    end else begin
                        gap_idx_next = gap_idx_reg + 1'b1;
                        state_next   = S_GAPRD;
                    end
                end
            end
            S_OUT2: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{char_out: (sec_upper_reg ? CHAR_UA : CHAR_LA)
                                                 + {3'd0, cell_val},
                                      last_of_run: 1'b1, status: ST_OK};
                    gap_count_next = '0;
                    if (doubled_reg) begin
                        // the second letter of a doubled pair carries over
                        pend_valid_next  = 1'b1;
                        pend_letter_next = cur_letter;
                        pend_upper_next  = is_upper;
                    end else begin
                        pend_valid_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            pend_valid_reg  <= 1'b0;
            pend_letter_reg <= 5'd0;
            pend_upper_reg  <= 1'b0;
            doubled_reg     <= 1'b0;
            scan_k_reg      <= 5'd0;
            gap_count_reg   <= '0;
            gap_idx_reg     <= '0;
            error_latch_reg <= ST_OK;
            out_valid_reg   <= 1'b0;
            cells_low_reg   <= '0;
            cells_high_reg  <= '0;
            cell_final_reg  <= '0;
            decrypt_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            pend_valid_reg  <= pend_valid_next;
            pend_letter_reg <= pend_letter_next;
            pend_upper_reg  <= pend_upper_next;
            doubled_reg     <= doubled_next;
            scan_k_reg      <= scan_k_next;
            gap_count_reg   <= gap_count_next;
            gap_idx_reg     <= gap_idx_next;
            error_latch_reg <= error_latch_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_we) begin
                case (cfg_addr)
                    REG_CELLS_LOW:  cells_low_reg  <= cfg_wdata;
                    REG_CELLS_HIGH: cells_high_reg <= cfg_wdata;
                    REG_CELL_FINAL: cell_final_reg <= cfg_wdata[CELL_W-1:0];
                    REG_DECRYPT:    decrypt_reg    <= cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        ch_reg         <= ch_next;
        eot_reg        <= eot_next;
        sec_letter_reg <= sec_letter_next;
        sec_upper_reg  <= sec_upper_next;
        pos1_reg       <= pos1_next;
        pos2_reg       <= pos2_next;
        o1_reg         <= o1_next;
        o2_reg         <= o2_next;
        out_data_reg   <= out_data_next;
    end

    // gap buffer
    always_ff @(posedge aclk) begin
        if (gap_we) begin
            gap_mem[gap_count_reg[GAP_IW-1:0]] <= ch_reg;
        end
        gap_rd_data_reg <= gap_mem[gap_idx_reg];
    end

`ifndef SYNTHESIS
    a_gap_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        gap_count_reg <= GAP_CW'(GAP_DEPTH))
        else $error("gap count beyond depth");

    a_latch_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (error_latch_reg != ST_OK) |=> (error_latch_reg == $past(error_latch_reg)))
        else $error("error latch changed");

    a_err_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg.status != ST_OK)
            |-> (out_data_reg.char_out == 8'd0 && out_data_reg.last_of_run))
        else $error("error result malformed");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_k_reg <= LAST_CELL)
        else $error("scan index beyond square");

    a_no_pending_after_err: assert property (@(posedge aclk) disable iff (!aresetn)
        (error_latch_reg != ST_OK) |-> (!pend_valid_reg && gap_count_reg == '0))
        else $error("pending state kept after error");
`endif

endmodule
